// File: rtl/core/spc_pkg.sv
package spc_pkg;

   localparam int CORDIC_STAGES_DEF = 16;
   localparam int ANGLE_BITS_DEF    = 16;

   localparam int RANGE_W   = 16;
   localparam int ANGLE_W   = 16;
   localparam int COORD_W   = 24;
   localparam int CSR_W     = 16;
   localparam int CSR_IDX_W = 2;
   // datapath width of the rotation: prescaled range with 16 fraction bits plus gain growth
   localparam int XY_W      = 35;
   // whole-millimetre offset after rounding
   localparam int CX_W      = XY_W - 16;

   localparam logic [CSR_IDX_W-1:0] CSR_START_ANGLE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ANGLE_STEP  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_RANGE   = 2'd2;

   localparam logic [RANGE_W-1:0] MAX_RANGE_RST = 16'd30000;

   // inverse CORDIC gain, 2^-30 units
   localparam logic [29:0] GAIN_Q30 = 30'h26DD3B6A;

   localparam int ATAN_LEN = 24;
   // atan(2^-i) in 2^-32 turn units
   localparam logic [31:0] ATAN_TURN32 [ATAN_LEN] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   // arctangent step of one stage, rounded half up to angle_bits per turn
   function automatic logic [31:0] atan_step(input int stage, input int angle_bits);
      logic [32:0] t;
      t = {1'b0, ATAN_TURN32[stage]} + (33'd1 << (31 - angle_bits));
      return 32'(t >> (32 - angle_bits));
   endfunction

   typedef struct packed {
      logic                      flip;
      logic                      last_point;
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
   } side_type;

   typedef struct packed {
      logic        [ANGLE_W-1:0] beam_angle;
      logic signed [COORD_W-1:0] origin_x;
      logic signed [COORD_W-1:0] origin_y;
   } state_type;

endpackage

// File: rtl/core/spc_front.sv
module spc_front #(
   parameter int ANGLE_BITS = spc_pkg::ANGLE_BITS_DEF,
   localparam int ZW = ANGLE_BITS + 2
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  advance,
   input  logic                                  req_valid,
   input  logic        [spc_pkg::RANGE_W-1:0]    req_range_mm,
   input  logic                                  req_range_finite,
   input  logic                                  req_first_beam,
   input  logic                                  req_last_beam,
   input  logic signed [spc_pkg::COORD_W-1:0]    req_pose_x,
   input  logic signed [spc_pkg::COORD_W-1:0]    req_pose_y,
   input  logic        [spc_pkg::ANGLE_W-1:0]    req_pose_heading,
   input  logic                                  csr_write_en,
   input  logic        [spc_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic        [spc_pkg::CSR_W-1:0]      csr_wdata,
   output logic                                  out_valid,
   output logic signed [spc_pkg::XY_W-1:0]       out_x,
   output logic signed [ZW-1:0]                  out_z,
   output spc_pkg::side_type                     out_side,
   output spc_pkg::state_type                    state
);

   localparam logic signed [ZW-1:0] QUARTER = ZW'(1) << (ANGLE_BITS - 2);
   localparam logic signed [ZW-1:0] HALF    = ZW'(1) << (ANGLE_BITS - 1);

   logic [spc_pkg::ANGLE_W-1:0] start_angle_ff, start_angle_in;
   logic [spc_pkg::ANGLE_W-1:0] angle_step_ff, angle_step_in;
   logic [spc_pkg::RANGE_W-1:0] max_range_ff, max_range_in;

   logic        [spc_pkg::ANGLE_W-1:0] beam_angle_ff, beam_angle_in;
   logic signed [spc_pkg::COORD_W-1:0] origin_x_ff, origin_x_in;
   logic signed [spc_pkg::COORD_W-1:0] origin_y_ff, origin_y_in;

   logic                            valid_ff, valid_in;
   logic signed [spc_pkg::XY_W-1:0] x_ff, x_in;
   logic signed [ZW-1:0]            z_ff, z_in;
   spc_pkg::side_type               side_ff, side_in;

   logic                          accept;
   logic [spc_pkg::RANGE_W-1:0]   range;
   logic [45:0]                   prod;
   logic [39:0]                   wide;
   logic [ANGLE_BITS-1:0]         za;
   logic signed [ZW-1:0]          zs;
   logic                          flip;

   assign accept = req_valid & advance;

   always_comb begin
      start_angle_in = start_angle_ff;
      angle_step_in  = angle_step_ff;
      max_range_in   = max_range_ff;
      if (csr_write_en) begin
         case (csr_index)
            spc_pkg::CSR_START_ANGLE: start_angle_in = csr_wdata;
            spc_pkg::CSR_ANGLE_STEP:  angle_step_in  = csr_wdata;
            spc_pkg::CSR_MAX_RANGE:   max_range_in   = csr_wdata;
            default: ;
         endcase
      end
   end

   always_comb begin
      beam_angle_in = beam_angle_ff;
      origin_x_in   = origin_x_ff;
      origin_y_in   = origin_y_ff;
      if (req_first_beam) begin
         beam_angle_in = req_pose_heading + start_angle_ff;
         origin_x_in   = req_pose_x;
         origin_y_in   = req_pose_y;
      end else begin
         beam_angle_in = beam_angle_ff + angle_step_ff;
      end
   end

   // prescale by the inverse gain, keep 16 fraction bits
   always_comb begin
      range = req_range_finite ? req_range_mm : max_range_ff;
      prod  = {30'd0, range} * {16'd0, spc_pkg::GAIN_Q30};
      x_in  = {3'b000, prod[45:14]};
   end

   // scale to ANGLE_BITS per turn, then fold into a quarter turn either side of zero
   always_comb begin
      wide = {beam_angle_in, 24'd0} >> (40 - ANGLE_BITS);
      za   = wide[ANGLE_BITS-1:0];
      zs   = {{2{za[ANGLE_BITS-1]}}, za};
      flip = 1'b0;
      z_in = zs;
      if (zs > QUARTER) begin
         z_in = zs - HALF;
         flip = 1'b1;
      end else if (zs < -QUARTER) begin
         z_in = zs + HALF;
         flip = 1'b1;
      end
      side_in.flip       = flip;
      side_in.last_point = req_last_beam;
      side_in.origin_x   = origin_x_in;
      side_in.origin_y   = origin_y_in;
      valid_in           = advance ? req_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_angle_ff <= '0;
         angle_step_ff  <= '0;
         max_range_ff   <= spc_pkg::MAX_RANGE_RST;
         beam_angle_ff  <= '0;
         origin_x_ff    <= '0;
         origin_y_ff    <= '0;
         valid_ff       <= 1'b0;
      end else begin
         start_angle_ff <= start_angle_in;
         angle_step_ff  <= angle_step_in;
         max_range_ff   <= max_range_in;
         valid_ff       <= valid_in;
         if (accept) begin
            beam_angle_ff <= beam_angle_in;
            origin_x_ff   <= origin_x_in;
            origin_y_ff   <= origin_y_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in;
         z_ff    <= z_in;
         side_ff <= side_in;
      end
   end

   assign out_valid        = valid_ff;
   assign out_x            = x_ff;
   assign out_z            = z_ff;
   assign out_side         = side_ff;
   assign state.beam_angle = beam_angle_ff;
   assign state.origin_x   = origin_x_ff;
   assign state.origin_y   = origin_y_ff;

endmodule

// File: rtl/core/spc_cell.sv
module spc_cell #(
   parameter int STAGE      = 0,
   parameter int ANGLE_BITS = spc_pkg::ANGLE_BITS_DEF,
   localparam int ZW = ANGLE_BITS + 2
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            advance,
   input  logic                            in_valid,
   input  logic signed [spc_pkg::XY_W-1:0] in_x,
   input  logic signed [spc_pkg::XY_W-1:0] in_y,
   input  logic signed [ZW-1:0]            in_z,
   input  spc_pkg::side_type               in_side,
   output logic                            out_valid,
   output logic signed [spc_pkg::XY_W-1:0] out_x,
   output logic signed [spc_pkg::XY_W-1:0] out_y,
   output logic signed [ZW-1:0]            out_z,
   output spc_pkg::side_type               out_side
);

   localparam logic signed [ZW-1:0] STEP = ZW'(spc_pkg::atan_step(STAGE, ANGLE_BITS));

   logic                            valid_ff, valid_in;
   logic signed [spc_pkg::XY_W-1:0] x_ff, x_in, y_ff, y_in, dx, dy;
   logic signed [ZW-1:0]            z_ff, z_in;
   spc_pkg::side_type               side_ff;

   // rotate toward zero residual angle
   always_comb begin
      dx = in_y >>> STAGE;
      dy = in_x >>> STAGE;
      if (!in_z[ZW-1]) begin
         x_in = in_x - dx;
         y_in = in_y + dy;
         z_in = in_z - STEP;
      end else begin
         x_in = in_x + dx;
         y_in = in_y - dy;
         z_in = in_z + STEP;
      end
      valid_in = advance ? in_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         z_ff    <= z_in;
         side_ff <= in_side;
      end
   end

   assign out_valid = valid_ff;
   assign out_x     = x_ff;
   assign out_y     = y_ff;
   assign out_z     = z_ff;
   assign out_side  = side_ff;

endmodule

// File: rtl/core/spc_back.sv
module spc_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               advance,
   input  logic                               in_valid,
   input  logic signed [spc_pkg::XY_W-1:0]    in_x,
   input  logic signed [spc_pkg::XY_W-1:0]    in_y,
   input  spc_pkg::side_type                  in_side,
   output logic                               rsp_valid,
   output logic signed [spc_pkg::COORD_W-1:0] rsp_end_x,
   output logic signed [spc_pkg::COORD_W-1:0] rsp_end_y,
   output logic                               rsp_last_point
);

   localparam int SUM_W = spc_pkg::COORD_W + 2;
   localparam logic signed [spc_pkg::XY_W-1:0] HALF_MM = spc_pkg::XY_W'(32768);
   localparam logic signed [SUM_W-1:0] SAT_HI = SUM_W'(8388607);
   localparam logic signed [SUM_W-1:0] SAT_LO = -SUM_W'(8388608);

   logic                            rnd_valid_ff, rnd_valid_in;
   logic signed [spc_pkg::CX_W-1:0] cx_ff, cy_ff;
   logic signed [spc_pkg::XY_W-1:0] rx, ry;
   spc_pkg::side_type               side_ff;

   logic                               valid_ff, valid_in;
   logic signed [spc_pkg::COORD_W-1:0] end_x_ff, end_x_in, end_y_ff, end_y_in;
   logic                               last_ff;
   logic signed [SUM_W-1:0]            sx, sy;

   // undo the half-turn fold and round to whole millimetres
   always_comb begin
      rx = in_side.flip ? HALF_MM - in_x : in_x + HALF_MM;
      ry = in_side.flip ? HALF_MM - in_y : in_y + HALF_MM;
      rnd_valid_in = advance ? in_valid : rnd_valid_ff;
   end

   always_comb begin
      sx = {{2{side_ff.origin_x[spc_pkg::COORD_W-1]}}, side_ff.origin_x}
         + {{(SUM_W - spc_pkg::CX_W){cx_ff[spc_pkg::CX_W-1]}}, cx_ff};
      sy = {{2{side_ff.origin_y[spc_pkg::COORD_W-1]}}, side_ff.origin_y}
         + {{(SUM_W - spc_pkg::CX_W){cy_ff[spc_pkg::CX_W-1]}}, cy_ff};
      if (sx > SAT_HI)      end_x_in = SAT_HI[spc_pkg::COORD_W-1:0];
      else if (sx < SAT_LO) end_x_in = SAT_LO[spc_pkg::COORD_W-1:0];
      else                  end_x_in = sx[spc_pkg::COORD_W-1:0];
      if (sy > SAT_HI)      end_y_in = SAT_HI[spc_pkg::COORD_W-1:0];
      else if (sy < SAT_LO) end_y_in = SAT_LO[spc_pkg::COORD_W-1:0];
      else                  end_y_in = sy[spc_pkg::COORD_W-1:0];
      valid_in = advance ? rnd_valid_ff : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rnd_valid_ff <= 1'b0;
         valid_ff     <= 1'b0;
      end else begin
         rnd_valid_ff <= rnd_valid_in;
         valid_ff     <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cx_ff    <= rx[spc_pkg::XY_W-1:16];
         cy_ff    <= ry[spc_pkg::XY_W-1:16];
         side_ff  <= in_side;
         end_x_ff <= end_x_in;
         end_y_ff <= end_y_in;
         last_ff  <= side_ff.last_point;
      end
   end

   assign rsp_valid      = valid_ff;
   assign rsp_end_x      = end_x_ff;
   assign rsp_end_y      = end_y_ff;
   assign rsp_last_point = last_ff;

endmodule

// File: rtl/core/scan_polar_to_cartesian.sv
// channel | ports                                   | moves
// req     | req_valid / req_ready, range + pose      | one scan sample per beat
// rsp     | rsp_valid / rsp_ready, end_x/end_y/last  | one endpoint per beat
// csr     | csr_write_en, csr_index, csr_wdata       | register write, no wait
//
// The path runs through one prescale/angle stage, one cell per
// rotation, a rounding stage and the output register. One beat per cycle
// enters when the output is free or being taken. A stalled result holds the
// whole row of cells in place. Reset clears the angle, origin and registers
// (max_range to 30000) and empties the row.
module scan_polar_to_cartesian #(
   parameter int CORDIC_STAGES = spc_pkg::CORDIC_STAGES_DEF,
   parameter int ANGLE_BITS    = spc_pkg::ANGLE_BITS_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic        [spc_pkg::RANGE_W-1:0]   req_range_mm,
   input  logic                                 req_range_finite,
   input  logic                                 req_first_beam,
   input  logic                                 req_last_beam,
   input  logic signed [spc_pkg::COORD_W-1:0]   req_pose_x,
   input  logic signed [spc_pkg::COORD_W-1:0]   req_pose_y,
   input  logic        [spc_pkg::ANGLE_W-1:0]   req_pose_heading,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic signed [spc_pkg::COORD_W-1:0]   rsp_end_x,
   output logic signed [spc_pkg::COORD_W-1:0]   rsp_end_y,
   output logic                                 rsp_last_point,
   input  logic                                 csr_write_en,
   input  logic        [spc_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic        [spc_pkg::CSR_W-1:0]     csr_wdata
);

   localparam int ZW = ANGLE_BITS + 2;

   logic                            advance;
   logic                            c_valid [CORDIC_STAGES+1];
   logic signed [spc_pkg::XY_W-1:0] c_x     [CORDIC_STAGES+1];
   logic signed [spc_pkg::XY_W-1:0] c_y     [CORDIC_STAGES+1];
   logic signed [ZW-1:0]            c_z     [CORDIC_STAGES+1];
   spc_pkg::side_type               c_side  [CORDIC_STAGES+1];
   spc_pkg::state_type              state;

   assign advance   = !rsp_valid || rsp_ready;
   assign req_ready = advance;
   assign c_y[0]    = '0;

   spc_front #(.ANGLE_BITS(ANGLE_BITS)) u_front (
      .clock            (clock),
      .reset            (reset),
      .advance          (advance),
      .req_valid        (req_valid),
      .req_range_mm     (req_range_mm),
      .req_range_finite (req_range_finite),
      .req_first_beam   (req_first_beam),
      .req_last_beam    (req_last_beam),
      .req_pose_x       (req_pose_x),
      .req_pose_y       (req_pose_y),
      .req_pose_heading (req_pose_heading),
      .csr_write_en     (csr_write_en),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .out_valid        (c_valid[0]),
      .out_x            (c_x[0]),
      .out_z            (c_z[0]),
      .out_side         (c_side[0]),
      .state            (state)
   );

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
      spc_cell #(.STAGE(i), .ANGLE_BITS(ANGLE_BITS)) u_cell (
         .clock     (clock),
         .reset     (reset),
         .advance   (advance),
         .in_valid  (c_valid[i]),
         .in_x      (c_x[i]),
         .in_y      (c_y[i]),
         .in_z      (c_z[i]),
         .in_side   (c_side[i]),
         .out_valid (c_valid[i+1]),
         .out_x     (c_x[i+1]),
         .out_y     (c_y[i+1]),
         .out_z     (c_z[i+1]),
         .out_side  (c_side[i+1])
      );
   end

   spc_back u_back (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .in_valid       (c_valid[CORDIC_STAGES]),
      .in_x           (c_x[CORDIC_STAGES]),
      .in_y           (c_y[CORDIC_STAGES]),
      .in_side        (c_side[CORDIC_STAGES]),
      .rsp_valid      (rsp_valid),
      .rsp_end_x      (rsp_end_x),
      .rsp_end_y      (rsp_end_y),
      .rsp_last_point (rsp_last_point)
   );

   // angle and origin move only on an accepted beat
   a_state_hold : assert property (@(posedge clock) disable iff (reset)
      !(req_valid && req_ready) |=> $stable(state))
      else $error("scan state changed without an accepted beat");

   // first beam latches the pose as origin
   a_origin_latch : assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_first_beam |=>
         state.origin_x == $past(req_pose_x) && state.origin_y == $past(req_pose_y))
      else $error("origin not latched on first beam");

   // a waiting result freezes the row and the input
   a_stall_blocks : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("input taken while result stalled");

endmodule

// File: dv/tb_top.sv
module tb_top;

   localparam int STAGES     = spc_pkg::CORDIC_STAGES_DEF;
   localparam int ABITS      = spc_pkg::ANGLE_BITS_DEF;
   localparam int STALL_MAX  = 4000;
   localparam int PHASE_BEAMS = 330;

   typedef longint unsigned u64_type;

   typedef struct packed {
      logic signed [spc_pkg::COORD_W-1:0] end_x;
      logic signed [spc_pkg::COORD_W-1:0] end_y;
      logic                               last_point;
   } endpoint_type;

   // atan(2^-i) in 2^-32 turn units
   localparam logic [31:0] ARCTAN_TURN [24] = '{
      32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
      32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
      32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
      32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D,
      32'h000028BE, 32'h0000145F, 32'h00000A30, 32'h00000518,
      32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051
   };

   logic                               clock = 1'b0;
   logic                               reset = 1'b1;
   logic                               req_valid = 1'b0;
   logic                               req_ready;
   logic        [spc_pkg::RANGE_W-1:0] req_range_mm = '0;
   logic                               req_range_finite = 1'b0;
   logic                               req_first_beam = 1'b0;
   logic                               req_last_beam = 1'b0;
   logic signed [spc_pkg::COORD_W-1:0] req_pose_x = '0;
   logic signed [spc_pkg::COORD_W-1:0] req_pose_y = '0;
   logic        [spc_pkg::ANGLE_W-1:0] req_pose_heading = '0;
   logic                               rsp_valid;
   logic                               rsp_ready = 1'b0;
   logic signed [spc_pkg::COORD_W-1:0] rsp_end_x;
   logic signed [spc_pkg::COORD_W-1:0] rsp_end_y;
   logic                               rsp_last_point;
   logic                               csr_write_en = 1'b0;
   logic      [spc_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic          [spc_pkg::CSR_W-1:0] csr_wdata = '0;

   // predictor copy of registers and scan state
   logic [15:0] cfg_start_angle = 16'd0;
   logic [15:0] cfg_angle_step  = 16'd0;
   logic [15:0] cfg_max_range   = 16'd30000;
   logic [15:0] cur_beam_angle  = 16'd0;
   longint      cur_origin_x    = 0;
   longint      cur_origin_y    = 0;

   endpoint_type pending_endpoints[$];
   int        n_fail = 0;
   int        snd_idle_pct = 0;
   int        rcv_stall_pct = 0;
   int        hold_request = 0;
   int        hold_left = 0;
   int        quiet_cycles = 0;

   scan_polar_to_cartesian #(
      .CORDIC_STAGES(STAGES),
      .ANGLE_BITS   (ABITS)
   ) i_dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_range_mm    (req_range_mm),
      .req_range_finite(req_range_finite),
      .req_first_beam  (req_first_beam),
      .req_last_beam   (req_last_beam),
      .req_pose_x      (req_pose_x),
      .req_pose_y      (req_pose_y),
      .req_pose_heading(req_pose_heading),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_end_x       (rsp_end_x),
      .rsp_end_y       (rsp_end_y),
      .rsp_last_point  (rsp_last_point),
      .csr_write_en    (csr_write_en),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   function automatic longint sat_coord(input longint v);
      if (v > 64'sd8388607) return 64'sd8388607;
      if (v < -64'sd8388608) return -64'sd8388608;
      return v;
   endfunction

   // advance the scan state by one beam and rotate its range onto the beam angle
   function automatic endpoint_type predict_endpoint(
      input logic [15:0] range_mm, input logic finite, input logic first, input logic last,
      input logic signed [23:0] pose_x, input logic signed [23:0] pose_y,
      input logic [15:0] heading);
      endpoint_type ep;
      u64_type   rng;
      longint    full, half, quarter, z, x, y, step, dx, dy;
      bit        flip;

      rng = finite ? u64_type'(range_mm) : u64_type'(cfg_max_range);
      if (first) begin
         cur_origin_x   = longint'(pose_x);
         cur_origin_y   = longint'(pose_y);
         cur_beam_angle = heading + cfg_start_angle;
      end else begin
         cur_beam_angle = cur_beam_angle + cfg_angle_step;
      end

      full    = 64'sd1 <<< ABITS;
      half    = full >>> 1;
      quarter = full >>> 2;
      z = longint'((u64_type'(cur_beam_angle) << 24) >> (40 - ABITS));
      flip = 1'b0;
      if (z >= half) z = z - full;
      // fold into a quarter turn either side of zero; a half-turn fold negates both
      if (z > quarter) begin
         z = z - half;
         flip = 1'b1;
      end else if (z < -quarter) begin
         z = z + half;
         flip = 1'b1;
      end

      x = longint'((rng * u64_type'(652032874)) >> 14);
      y = 0;
      for (int i = 0; i < STAGES && i < 24; i++) begin
         step = longint'((u64_type'(ARCTAN_TURN[i]) + (u64_type'(1) << (31 - ABITS)))
                         >> (32 - ABITS));
         dx = y >>> i;
         dy = x >>> i;
         if (z >= 0) begin
            x = x - dx;
            y = y + dy;
            z = z - step;
         end else begin
            x = x + dx;
            y = y - dy;
            z = z + step;
         end
      end
      if (flip) begin
         x = -x;
         y = -y;
      end
      ep.end_x      = spc_pkg::COORD_W'(sat_coord(cur_origin_x + ((x + 32768) >>> 16)));
      ep.end_y      = spc_pkg::COORD_W'(sat_coord(cur_origin_y + ((y + 32768) >>> 16)));
      ep.last_point = last;
      return ep;
   endfunction

   // scoreboard: check the result beat, then predict the accepted sample
   always @(posedge clock) begin
      endpoint_type want;
      endpoint_type ep_new;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_endpoints.size() == 0) begin
            n_fail++;
            if (n_fail <= 10)
               $display("unexpected endpoint x=%0d y=%0d last=%0b",
                        rsp_end_x, rsp_end_y, rsp_last_point);
         end else begin
            want = pending_endpoints.pop_front();
            if (rsp_end_x !== want.end_x || rsp_end_y !== want.end_y ||
                rsp_last_point !== want.last_point) begin
               n_fail++;
               if (n_fail <= 10)
                  $display({"endpoint mismatch: expected x=%0d y=%0d last=%0b, ",
                            "got x=%0d y=%0d last=%0b"},
                           want.end_x, want.end_y, want.last_point,
                           rsp_end_x, rsp_end_y, rsp_last_point);
            end
         end
      end
      if (!reset && req_valid && req_ready) begin
         ep_new = predict_endpoint(req_range_mm, req_range_finite, req_first_beam,
                                   req_last_beam, req_pose_x, req_pose_y, req_pose_heading);
         pending_endpoints.insert(pending_endpoints.size(), ep_new);
      end
   end

   // result side: random stalls, or a long hold-off when one is requested
   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left = hold_request;
         hold_request = 0;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rcv_stall_pct);
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         quiet_cycles = 0;
      else
         quiet_cycles++;
      if (quiet_cycles >= STALL_MAX) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   task automatic send_beam(
      input logic [15:0] range_mm, input logic finite, input logic first, input logic last,
      input logic signed [23:0] pose_x, input logic signed [23:0] pose_y,
      input logic [15:0] heading);
      int gap;
      gap = 0;
      while (gap < 40 && $urandom_range(99) < snd_idle_pct) gap++;
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_range_mm     <= range_mm;
      req_range_finite <= finite;
      req_first_beam   <= first;
      req_last_beam    <= last;
      req_pose_x       <= pose_x;
      req_pose_y       <= pose_y;
      req_pose_heading <= heading;
      req_valid        <= 1'b1;
      do @(posedge clock); while (!req_ready);
   endtask

   // drop valid and wait until every predicted endpoint has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(posedge clock); while (pending_endpoints.size() != 0);
   endtask

   task automatic write_reg(input logic [spc_pkg::CSR_IDX_W-1:0] idx, input logic [15:0] data);
      csr_write_en <= 1'b1;
      csr_index    <= idx;
      csr_wdata    <= data;
      @(posedge clock);
      case (idx)
         spc_pkg::CSR_START_ANGLE: cfg_start_angle = data;
         spc_pkg::CSR_ANGLE_STEP:  cfg_angle_step  = data;
         spc_pkg::CSR_MAX_RANGE:   cfg_max_range   = data;
         default: ;
      endcase
      csr_write_en <= 1'b0;
      @(posedge clock);
   endtask

   function automatic logic [15:0] rand_range();
      case ($urandom_range(9))
         0: return 16'd0;
         1: return 16'hFFFF;
         default: return 16'($urandom_range(65535));
      endcase
   endfunction

   function automatic logic [23:0] rand_coord();
      case ($urandom_range(7))
         0: return 24'h7FFFFF;
         1: return 24'h800000;
         2: return 24'($urandom_range(4000)) - 24'd2000;
         default: return 24'($urandom);
      endcase
   endfunction

   task automatic test_directed();
      logic [15:0] headings [9] = '{16'h4000, 16'h4001, 16'h3FFF, 16'hC000, 16'hBFFF,
                                    16'hFFFF, 16'h7FFF, 16'h8001, 16'h0001};
      snd_idle_pct  = 0;
      rcv_stall_pct = 0;
      // later beam before any first beam: reset origin and angle
      send_beam(16'd1000, 1'b1, 1'b0, 1'b0, rand_coord(), rand_coord(), 16'h2000);
      // one-beam scan, saturating high
      send_beam(16'hFFFF, 1'b1, 1'b1, 1'b1, 24'sh7FFFFF, 24'sh7FFFFF, 16'h0000);
      send_beam(16'hFFFF, 1'b1, 1'b1, 1'b0, -24'sh800000, -24'sh800000, 16'h8000);
      send_beam(16'd0, 1'b1, 1'b0, 1'b0, rand_coord(), rand_coord(), 16'h1234);
      send_beam(16'd12345, 1'b0, 1'b0, 1'b1, rand_coord(), rand_coord(), 16'h0000);
      foreach (headings[i])
         send_beam(16'd50000, 1'b1, 1'b1, 1'b1, 24'sd0, 24'sd0, headings[i]);
      wait_drained();
      write_reg(spc_pkg::CSR_START_ANGLE, 16'h8000);
      write_reg(spc_pkg::CSR_ANGLE_STEP, 16'h7FFF);
      write_reg(spc_pkg::CSR_MAX_RANGE, 16'hFFFF);
      send_beam(16'd40000, 1'b1, 1'b1, 1'b0, -24'sd100, 24'sd200, 16'h8000);
      send_beam(16'd0, 1'b0, 1'b0, 1'b0, rand_coord(), rand_coord(), 16'h0000);
      send_beam(16'd777, 1'b1, 1'b0, 1'b0, rand_coord(), rand_coord(), 16'h0000);
      send_beam(16'd1, 1'b1, 1'b0, 1'b1, rand_coord(), rand_coord(), 16'h0000);
      wait_drained();
      write_reg(spc_pkg::CSR_START_ANGLE, 16'h7FFF);
      write_reg(spc_pkg::CSR_ANGLE_STEP, 16'h8000);
      write_reg(spc_pkg::CSR_MAX_RANGE, 16'd0);
      send_beam(16'hFFFF, 1'b0, 1'b1, 1'b0, 24'sd5000, -24'sd5000, 16'hFFFF);
      send_beam(16'd30000, 1'b1, 1'b0, 1'b0, rand_coord(), rand_coord(), 16'h0000);
      send_beam(16'd100, 1'b0, 1'b0, 1'b1, rand_coord(), rand_coord(), 16'h0000);
      wait_drained();
   endtask

   // mostly well-formed scans with random content; some stray beams and open scans
   task automatic send_random_scans(input int n_beams);
      int  sent, kind, beams;
      bit  close_scan;
      sent = 0;
      while (sent < n_beams) begin
         kind = $urandom_range(99);
         if (kind < 12) begin
            send_beam(16'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
                      24'($urandom), 24'($urandom), 16'($urandom));
            sent++;
         end else begin
            beams = ($urandom_range(3) == 0) ? $urandom_range(1, 60) : $urandom_range(1, 12);
            close_scan = (kind >= 20);
            for (int b = 0; b < beams; b++) begin
               send_beam(rand_range(), $urandom_range(9) != 0, b == 0,
                         close_scan && b == beams - 1, rand_coord(), rand_coord(),
                         16'($urandom));
               sent++;
            end
         end
      end
   endtask

   task automatic test_random_phases();
      int idle_mix [4][2] = '{'{0, 0}, '{83, 0}, '{0, 83}, '{31, 31}};
      for (int p = 0; p < 4; p++) begin
         wait_drained();
         write_reg(spc_pkg::CSR_START_ANGLE, 16'($urandom));
         write_reg(spc_pkg::CSR_ANGLE_STEP, ($urandom_range(1) == 0) ? 16'($urandom)
                                   : 16'($urandom_range(2000)) - 16'd1000);
         write_reg(spc_pkg::CSR_MAX_RANGE, 16'($urandom));
         snd_idle_pct  = idle_mix[p][0];
         rcv_stall_pct = idle_mix[p][1];
         send_random_scans(PHASE_BEAMS);
      end
   endtask

   // hold the result side long enough for the row to fill and stall the input
   task automatic test_input_stall();
      wait_drained();
      snd_idle_pct  = 0;
      rcv_stall_pct = 0;
      hold_request  = 300;
      for (int b = 0; b < 80; b++)
         send_beam(rand_range(), 1'b1, b == 0, b == 79, rand_coord(), rand_coord(),
                   16'($urandom));
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phases();
      test_input_stall();
      wait_drained();
      repeat (STAGES + 10) @(posedge clock);
      if (n_fail == 0 && pending_endpoints.size() == 0)
         $display("Regression PASS");
      else
         $display("Regression FAIL");
      $finish;
   end

endmodule
